>>> rtl/mst_pkg.sv
// Shared types and constants for the Prim spanning tree block.
// Used by mst_scan and prim_minimum_spanning_tree; no dependencies.
package mst_pkg;

	localparam int MAX_V     = 16;
	localparam int VID_W     = $clog2(MAX_V);
	localparam int ADDR_W    = 2 * VID_W;
	localparam int RAM_DEPTH = MAX_V * MAX_V;
	localparam int WGT_W     = 16;
	localparam int TOT_W     = 20;
	localparam int CNT_W     = 5;
	localparam int IN_W      = 24;
	localparam int OUT_W     = 48;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [WGT_W-1:0] best;
		logic [VID_W-1:0] bf;
		logic [VID_W-1:0] bt;
	} scan_st_t;

endpackage

>>> rtl/prim_minimum_spanning_tree.sv
// Top level: weight store, visited set, run sequencer and output register.
// Depends on mst_pkg, mst_ram and mst_scan.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser cmd, tdata row/col/weight
//  m_      | out | m_tvalid/m_tready  | tuser edge_valid, tdata edge, tlast
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data vertex_count
//
// A load beat writes one weight. A run does one scan of all n*n matrix entries
// per chosen edge plus one final scan, n = active vertex count.
// Reset clears the weight store through per-entry valid bits, no sweep.
// While the output register holds an unaccepted beat, the sequencer waits.
module prim_minimum_spanning_tree (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mst_pkg::IN_W-1:0]    s_tdata,  // row[3:0] col[7:4] weight[23:8]
	input  logic                        s_tuser,  // cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mst_pkg::OUT_W-1:0]   m_tdata,  // from[3:0] to[7:4] cost[23:8] total[43:24]
	output logic                        m_tuser,  // edge_valid
	output logic                        m_tlast,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mst_pkg::CNT_W-1:0]   cfg_data
);
	import mst_pkg::*;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] vcnt_q, vcount;
	logic [MAX_V-1:0] visited_q;
	logic [TOT_W-1:0] total_q, total_sat;
	logic [TOT_W:0]   sum;
	logic             pend_q;
	logic [VID_W-1:0] pf_q, pt_q;
	logic [WGT_W-1:0] pc_q;
	logic [TOT_W-1:0] ptot_q;
	logic [RAM_DEPTH-1:0] vld_q;
	logic             vld_rd_q;
	logic [WGT_W-1:0] ram_dout, rd_wgt;
	logic             rd_en;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic             load_we, run_go;
	logic             scan_start, out_free, push_go, out_load;
	scan_st_t         scan_st;

	logic             m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	assign vcount = (vcnt_q == '0) ? CNT_W'(1)
		: ((vcnt_q > CNT_W'(MAX_V)) ? CNT_W'(MAX_V) : vcnt_q);

	assign wr_addr = {s_tdata[VID_W-1:0], s_tdata[2*VID_W-1:VID_W]};
	assign load_we = s_tvalid && s_tready && (s_tuser == CMD_LOAD);
	assign run_go  = s_tvalid && s_tready && (s_tuser == CMD_RUN);
	assign rd_wgt  = vld_rd_q ? ram_dout : '0;

	assign sum       = {1'b0, total_q} + (TOT_W + 1)'(scan_st.best);
	assign total_sat = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
	assign out_free  = !m_tvalid_q || m_tready;

	mst_ram #(
		.WIDTH(WGT_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(wr_addr),
		.wdata(s_tdata[2*VID_W+WGT_W-1:2*VID_W]),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_dout)
	);

	mst_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.vcount (vcount),
		.visited(visited_q),
		.rd_wgt (rd_wgt),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.st     (scan_st)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (run_go) state_d = ST_START;
			ST_START: state_d = ST_WAIT;
			ST_WAIT:  if (scan_st.done) state_d = ST_PUSH;
			ST_PUSH: begin
				if (out_free) state_d = scan_st.found ? ST_START : ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		scan_start = (state_q == ST_START);
		push_go    = (state_q == ST_PUSH) && out_free;
		out_load   = push_go && (!scan_st.found || pend_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vcnt_q     <= CNT_W'(MAX_V);
			visited_q  <= '0;
			total_q    <= '0;
			pend_q     <= 1'b0;
			vld_q      <= '0;
			vld_rd_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				vcnt_q <= cfg_data;
			end
			if (load_we) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
			end
			if (run_go) begin
				visited_q <= MAX_V'(1);
				total_q   <= '0;
				pend_q    <= 1'b0;
			end else if (push_go && scan_st.found) begin
				visited_q[scan_st.bt] <= 1'b1;
				total_q <= total_sat;
				pend_q  <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_go && scan_st.found) begin
			pf_q   <= scan_st.bf;
			pt_q   <= scan_st.bt;
			pc_q   <= scan_st.best;
			ptot_q <= total_sat;
		end
		if (out_load) begin
			m_tuser_q <= pend_q;
			m_tlast_q <= !scan_st.found;
			m_tdata_q <= pend_q
				? OUT_W'({ptot_q, pc_q, pt_q, pf_q})
				: '0;
		end
	end

	// note: assertions
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		scan_st.done |-> (state_q == ST_WAIT))
		else $error("scan done outside wait state");

	a_root_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> visited_q[0])
		else $error("root vertex not visited during run");

	a_noedge_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("empty result beat without tlast");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && m_tvalid_q) |-> m_tready)
		else $error("output beat overwritten");

endmodule

>>> rtl/mst_ram.sv
// Generic single write port RAM with registered read.
// No dependencies.
module mst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mst_scan.sv
// Matrix scan unit: walks rows and columns, one shared compare keeps the best edge.
// Depends on mst_pkg; reads the weight RAM through rd_en/rd_addr.
module mst_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mst_pkg::CNT_W-1:0]     vcount,
	input  logic [mst_pkg::MAX_V-1:0]     visited,
	input  logic [mst_pkg::WGT_W-1:0]     rd_wgt,
	output logic                          rd_en,
	output logic [mst_pkg::ADDR_W-1:0]    rd_addr,
	output mst_pkg::scan_st_t             st
);
	import mst_pkg::*;

	logic             busy_q;
	logic [VID_W-1:0] i_q, j_q;
	logic [VID_W-1:0] i_s1, j_s1;
	logic             v_s1, last_s1;
	logic             done_q, found_q;
	logic [WGT_W-1:0] best_q;
	logic [VID_W-1:0] bf_q, bt_q;
	logic [VID_W-1:0] nm1;
	logic             last_addr;
	logic             take;

	assign nm1       = VID_W'(vcount - CNT_W'(1));
	assign last_addr = (i_q == nm1) && (j_q == nm1);
	assign rd_en     = busy_q;
	assign rd_addr   = {i_q, j_q};

	assign take = v_s1 && (rd_wgt != '0) && visited[i_s1] && !visited[j_s1]
		&& (!found_q || (rd_wgt < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			done_q  <= v_s1 && last_s1;
			v_s1    <= busy_q;
			last_s1 <= busy_q && last_addr;
			if (start) begin
				busy_q  <= 1'b1;
				i_q     <= '0;
				j_q     <= '0;
				found_q <= 1'b0;
			end else begin
				if (busy_q) begin
					if (last_addr) begin
						busy_q <= 1'b0;
					end
					if (j_q == nm1) begin
						j_q <= '0;
						i_q <= i_q + VID_W'(1);
					end else begin
						j_q <= j_q + VID_W'(1);
					end
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		i_s1 <= i_q;
		j_s1 <= j_q;
		if (take) begin
			best_q <= rd_wgt;
			bf_q   <= i_s1;
			bt_q   <= j_s1;
		end
	end

	always_comb begin
		st.done  = done_q;
		st.found = found_q;
		st.best  = best_q;
		st.bf    = bf_q;
		st.bt    = bt_q;
	end

endmodule
